// ----- src/s2d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
package s2d_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	typedef logic [VALUE_W-1:0] mag_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0]  char_t;

endpackage
`default_nettype wire

// ----- src/s2d_bcd_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_bcd_step
// One shift-and-add-3 step: corrects every bcd digit of five or more by
// adding three, then shifts the bcd word left by one taking in a new bit.
// ----------------------------------------------------------------------------
module s2d_bcd_step (
	input  wire s2d_pkg::bcd_t bcd_in,
	input  wire                bit_in,
	output s2d_pkg::bcd_t      bcd_out
);
	import s2d_pkg::*;

	bcd_t adj;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_in[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule
`default_nettype wire

// ----- src/signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Prints a signed 32-bit integer as decimal ASCII, one character per word.
// ----------------------------------------------------------------------------
// One number is taken at a time. After accept the magnitude is converted to
// ten bcd digits by a shared shift-and-add-3 step over its 32 bits, leading
// zero digits are then dropped at one per cycle (up to nine), and the sign
// and digits leave one per cycle while char_stall is low, most significant
// first, with last_char set on the final one. The input stalls until the
// last character has been loaded into the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  signed [31:0]   value,
	input  wire                  value_valid,
	output logic                 value_stall,
	output s2d_pkg::char_t       ascii_char,
	output logic                 last_char,
	output logic                 char_valid,
	input  wire                  char_stall
);
	import s2d_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [4:0] bitcnt_q;
	logic [3:0] cnt_q;
	logic       neg_q;
	mag_t       bin_q;
	bcd_t       bcd_q;
	bcd_t       bcd_next;
	char_t      char_q;
	logic       last_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       load_char;
	digit_t     top_digit;

	s2d_bcd_step u_step (
		.bcd_in  (bcd_q),
		.bit_in  (bin_q[VALUE_W-1]),
		.bcd_out (bcd_next)
	);

	assign top_digit   = bcd_q[BCD_W-1 -: DIGIT_W];
	assign slot_free   = !out_valid_q || !char_stall;
	assign load_char   = slot_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign value_stall = (state_q != ST_IDLE);
	assign ascii_char  = char_q;
	assign last_char   = last_q;
	assign char_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			bitcnt_q    <= '0;
			cnt_q       <= '0;
		end else begin
			if (load_char) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !char_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						neg_q    <= value[VALUE_W-1];
						bin_q    <= value[VALUE_W-1] ? (mag_t'(0) - mag_t'(value))
						                             : mag_t'(value);
						bcd_q    <= '0;
						bitcnt_q <= '0;
						state_q  <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q    <= bcd_next;
					bin_q    <= {bin_q[VALUE_W-2:0], 1'b0};
					bitcnt_q <= bitcnt_q + 5'd1;
					if (bitcnt_q == 5'd31) begin
						cnt_q   <= 4'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == 4'd0 && cnt_q > 4'd1) begin
						bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						cnt_q <= cnt_q - 4'd1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						char_q      <= CHAR_ZERO + char_t'(top_digit);
						last_q      <= (cnt_q == 4'd1);
						bcd_q       <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						cnt_q       <= cnt_q - 4'd1;
						if (cnt_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- dv/signed_int_to_decimal_ascii_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Self-checking bench for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
// A directed list of boundary numbers is sent first: zero, plus and minus
// one, several power-of-ten boundaries, the largest positive value and the most
// negative value. Random numbers follow, spread over every string length and
// both signs. Each accepted number is converted to its expected characters by
// a local decimal printer. Every character word leaving the core is checked
// against the oldest expected one, both the code and the last flag. Both
// channels idle in random bursts, and the sender waits twice for the core to
// drain completely.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;
	import s2d_pkg::*;

	typedef struct packed {
		char_t ch;
		logic  last;
	} char_word_t;

	typedef struct {
		logic [31:0] v;
		bit          drain;
	} number_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic signed [31:0] value = '0;
	logic               value_valid = 1'b0;
	logic               value_stall;
	char_t              ascii_char;
	logic               last_char;
	logic               char_valid;
	logic               char_stall = 1'b0;

	number_item_t pending_q[$];
	char_word_t   expected_chars_q[$];

	int errors = 0;
	int numbers_sent = 0;
	int negatives_sent = 0;
	int chars_checked = 0;
	int send_gap = 0;
	int stall_left = 0;
	int cur_len = 0;
	bit [11:0] lengths_seen = '0;

	signed_int_to_decimal_ascii_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.ascii_char (ascii_char),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// sign then digits, most significant first
	function automatic void predict_chars(input logic [31:0] v);
		logic [31:0] mag;
		digit_t      digs[10];
		int          nd;
		int          total;
		int          k;
		mag = v[31] ? (32'd0 - v) : v;
		nd = 0;
		while (nd == 0 || (mag != 0 && nd < 10)) begin
			digs[nd] = digit_t'(mag % 10);
			mag = mag / 10;
			nd++;
		end
		total = nd + (v[31] ? 1 : 0);
		k = 0;
		if (v[31]) begin
			expected_chars_q.push_back('{CHAR_MINUS, (k + 1 == total)});
			k++;
		end
		for (int i = nd - 1; i >= 0; i--) begin
			expected_chars_q.push_back('{char_t'(CHAR_ZERO + digs[i]), (k + 1 == total)});
			k++;
		end
	endfunction

	function automatic logic [31:0] random_number();
		logic [31:0] mag;
		int          ndig;
		int unsigned lim;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: begin
				ndig = $urandom_range(1, 10);
				if (ndig == 10) begin
					mag = $urandom & 32'h7FFF_FFFF;
				end else begin
					lim = 1;
					for (int i = 0; i < ndig; i++) lim = lim * 10;
					mag = $urandom_range(0, lim - 1);
				end
				return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end
		endcase
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid <= 1'b0;
			value <= '0;
			send_gap <= 0;
		end else begin
			if (value_valid && !value_stall) begin
				predict_chars(value);
				numbers_sent++;
				if (value[31]) negatives_sent++;
			end
			if (!value_valid || !value_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					value_valid <= 1'b0;
				end else if (pending_q.size() == 0 ||
						(pending_q[0].drain && expected_chars_q.size() != 0)) begin
					value_valid <= 1'b0;
				end else if (pending_q.size() > 25 && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(1, 9) - 1;
					value_valid <= 1'b0;
				end else begin
					value <= pending_q[0].v;
					value_valid <= 1'b1;
					void'(pending_q.pop_front());
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		char_word_t exp_word;
		if (!arst_n) begin
			char_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (char_valid && !char_stall) begin
				if (expected_chars_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word ch=%0d last=%0b",
						ascii_char, last_char));
				end else begin
					exp_word = expected_chars_q.pop_front();
					chars_checked++;
					cur_len++;
					if (ascii_char !== exp_word.ch)
						report_mismatch($sformatf("ascii_char %0d, expected %0d",
							ascii_char, exp_word.ch));
					if (last_char !== exp_word.last)
						report_mismatch($sformatf("last_char %0b, expected %0b",
							last_char, exp_word.last));
					if (exp_word.last) begin
						if (cur_len <= 11) lengths_seen[cur_len] = 1'b1;
						cur_len = 0;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				char_stall <= 1'b1;
			end else if (pending_q.size() > 25 && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 9) - 1;
				char_stall <= 1'b1;
			end else begin
				char_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [31:0] directed[$];
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
			32'd100, -32'sd999, 32'd12345, 32'd999_999_999, 32'd1_000_000_000,
			-32'sd1_000_000_000, 32'd123_456_789, -32'sd9, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd1_234_567_890, -32'sd2_147_483_646};
		foreach (directed[i]) pending_q.push_back('{directed[i], 1'b0});
		for (int i = 0; i < 200; i++)
			pending_q.push_back('{random_number(), (i == 0 || i == 100)});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || value_valid) @(posedge clk);
		while (expected_chars_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered %0d numbers (%0d negative), %0d characters checked",
			numbers_sent, negatives_sent, chars_checked);
		$display("string lengths seen (bit n = length n): %b", lengths_seen);
		if (errors == 0 && expected_chars_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d words still expected", expected_chars_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/s2d_pkg.sv
src/s2d_bcd_step.sv
src/signed_int_to_decimal_ascii_core.sv
dv/signed_int_to_decimal_ascii_core_tb.sv
